/* rtl/core/bpa_pkg.sv */
// Shared constants, status codes and types of the bitmap page allocator.
package bpa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int MAP_WORDS  = 2048;

  localparam int WORD_W   = 64;
  localparam int BIT_W    = 6;
  localparam int WIDX_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W    = $clog2(MAP_WORDS + 1);
  localparam int PNUM_W   = WIDX_W + BIT_W;

  localparam int IN_ADDR_W  = 48;
  localparam int OUT_ADDR_W = 29;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 18;
  localparam int INPG_W     = IN_ADDR_W - PAGE_SHIFT;

  localparam longint PAGE_LIMIT = longint'(MAP_WORDS) * 64;

  localparam logic [WORD_W-1:0] ALL_USED = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd4;

  typedef struct packed {
    logic             full;
    logic [BIT_W-1:0] idx;
  } scan_res_t;

endpackage

/* rtl/core/bpa_if.sv */
// Request and result channel interfaces of the bitmap page allocator.
interface bpa_in_if;
  import bpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [IN_ADDR_W-1:0] free_address;

  modport source (output valid, output operation, output free_address, input ready);
  modport sink   (input valid, input operation, input free_address, output ready);
endinterface

interface bpa_out_if;
  import bpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] page_address;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_W-1:0]    pages_free;

  modport source (output valid, output page_address, output status, output pages_free,
                  input ready);
  modport sink   (input valid, input page_address, input status, input pages_free,
                  output ready);
endinterface

/* rtl/core/bpa_bitmap.sv */
// Usage bitmap store: one write port, one read port with registered data.
module bpa_bitmap (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bpa_pkg::WIDX_W-1:0]  waddr,
  input  logic [bpa_pkg::WORD_W-1:0]  wdata,
  input  logic                        re,
  input  logic [bpa_pkg::WIDX_W-1:0]  raddr,
  output logic [bpa_pkg::WORD_W-1:0]  rdata
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bpa_word_scan.sv */
// Word scan unit: all-used test and lowest clear bit of one bitmap word.
module bpa_word_scan (
  input  logic [bpa_pkg::WORD_W-1:0] word,
  output bpa_pkg::scan_res_t         res
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] low_onehot;
  logic [BIT_W-1:0]  idx;

  // isolate the lowest zero as a one-hot mask
  assign low_onehot = ~word & (word + WORD_W'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_onehot[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
  end

  assign res.full = &word;
  assign res.idx  = idx;

endmodule

/* rtl/core/bitmap_page_allocator_unit.sv */
// Bitmap page allocator top level: request sequencer, counters and result register.
// After reset the block sweeps the bitmap to all used, one word a cycle, over all
// MAP_WORDS (2048) words, and takes no request meanwhile; the tracked-pages
// register may be written at any time. Requests are then served one at a time,
// paced by the bitmap's single read port, which delivers one 64-bit word a cycle.
// An allocation reads words from the cursor on, with wrap, until one holds a free
// page, which it marks used, or all MAP_WORDS words were read (out of memory);
// an accepted free reads, checks and updates its word, and a rejected free goes
// straight to the result. The next request is taken in the cycle after the result
// is loaded into the output register, provided that register is empty or being drained.
module bitmap_page_allocator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  bpa_in_if.sink                       in_ch,
  bpa_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::COUNT_W-1:0]  cfg_wdata
);
  import bpa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREAD = 3'd3;
  localparam logic [2:0] S_FEVAL = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [WIDX_W-1:0]     clr_r;
  logic [WIDX_W-1:0]     cursor_r;
  logic [COUNT_W-1:0]    free_total_r;
  logic [COUNT_W-1:0]    tracked_r;
  logic [WIDX_W-1:0]     iss_w_r;
  logic [CNT_W-1:0]      iss_n_r;
  logic                  pend_r;
  logic [WIDX_W-1:0]     pend_w_r;
  logic [WIDX_W-1:0]     fw_r;
  logic [BIT_W-1:0]      fb_r;
  logic [OUT_ADDR_W-1:0] res_addr_r;
  logic [STATUS_W-1:0]   res_status_r;
  logic                  out_valid_r;
  logic [OUT_ADDR_W-1:0] out_addr_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_free_r;

  logic                  mem_we, mem_re;
  logic [WIDX_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0]     mem_wdata, rd_data;
  scan_res_t             scan;

  logic                  found, all_issued, can_issue, out_free_slot, in_acc;
  logic [INPG_W-1:0]     in_page;
  logic                  in_unaligned, in_outside;
  logic [PNUM_W-1:0]     found_page;
  logic [63:0]           found_addr;
  logic                  fbit_used;

  bpa_bitmap u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  bpa_word_scan u_scan (
    .word (rd_data),
    .res  (scan)
  );

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_free_slot = !out_valid_r || out_ch.ready;

  assign in_page      = in_ch.free_address[IN_ADDR_W-1:PAGE_SHIFT];
  assign in_unaligned = (in_ch.free_address[PAGE_SHIFT-1:0] != '0);
  // page beyond the smaller of the register and the bitmap size
  assign in_outside   = (64'(in_page) >= 64'(tracked_r)) || (64'(in_page) >= 64'(PAGE_LIMIT));

  assign found      = pend_r && !scan.full;
  assign all_issued = (iss_n_r == CNT_W'(MAP_WORDS));
  assign can_issue  = !all_issued && !found;
  assign found_page = {pend_w_r, scan.idx};
  assign found_addr = 64'(found_page) << PAGE_SHIFT;
  assign fbit_used  = rd_data[fb_r];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_w_r;
    mem_wdata = rd_data | (WORD_W'(1) << scan.idx);
    mem_re    = 1'b0;
    mem_raddr = iss_w_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = ALL_USED;
      end
      S_SCAN: begin
        mem_re = can_issue;
        mem_we = found;
      end
      S_FREAD: begin
        mem_re    = 1'b1;
        mem_raddr = fw_r;
      end
      S_FEVAL: begin
        mem_we    = fbit_used;
        mem_waddr = fw_r;
        mem_wdata = rd_data & ~(WORD_W'(1) << fb_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == WIDX_W'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_ALLOC) state_nxt = S_SCAN;
          else if (in_unaligned || in_outside) state_nxt = S_DONE;
          else state_nxt = S_FREAD;
        end
      end
      S_SCAN: if (found || (pend_r && all_issued)) state_nxt = S_DONE;
      S_FREAD: state_nxt = S_FEVAL;
      S_FEVAL: state_nxt = S_DONE;
      S_DONE: if (out_free_slot) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      cursor_r     <= '0;
      free_total_r <= '0;
      tracked_r    <= '0;
      iss_w_r      <= '0;
      iss_n_r      <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tracked_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: clr_r <= clr_r + WIDX_W'(1);
        S_IDLE: begin
          iss_w_r <= cursor_r;
          iss_n_r <= '0;
          pend_r  <= 1'b0;
        end
        S_SCAN: begin
          if (found) begin
            free_total_r <= free_total_r - COUNT_W'(1);
            cursor_r     <= pend_w_r;
          end
          if (can_issue) begin
            // advance the read pointer with wrap
            if (iss_w_r == WIDX_W'(MAP_WORDS - 1)) iss_w_r <= '0;
            else iss_w_r <= iss_w_r + WIDX_W'(1);
            iss_n_r <= iss_n_r + CNT_W'(1);
            pend_r  <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
        end
        S_FEVAL: begin
          if (fbit_used) begin
            free_total_r <= free_total_r + COUNT_W'(1);
            if (fw_r < cursor_r) cursor_r <= fw_r;
          end
        end
        S_DONE: begin
          if (out_free_slot) begin
            out_valid_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        fw_r       <= in_page[PNUM_W-1:BIT_W];
        fb_r       <= in_page[BIT_W-1:0];
        res_addr_r <= '0;
        if (in_unaligned) res_status_r <= ST_UNALIGNED;
        else res_status_r <= ST_OUTSIDE;
      end
      S_SCAN: begin
        if (can_issue) pend_w_r <= iss_w_r;
        if (found) begin
          res_addr_r   <= found_addr[OUT_ADDR_W-1:0];
          res_status_r <= ST_OK;
        end else begin
          res_status_r <= ST_OOM;
        end
      end
      S_FEVAL: begin
        if (fbit_used) res_status_r <= ST_OK;
        else res_status_r <= ST_DOUBLE;
      end
      S_DONE: begin
        if (out_free_slot) begin
          out_addr_r   <= res_addr_r;
          out_status_r <= res_status_r;
          out_free_r   <= free_total_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.page_address = out_addr_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.pages_free   = out_free_r;

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word appeared outside the done step");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("request taken during the clearing pass");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_addr_r == '0)
    else $error("nonzero page address with an error status");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> iss_n_r <= CNT_W'(MAP_WORDS))
    else $error("scan ran past the bitmap size");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    64'(free_total_r) <= 64'(PAGE_LIMIT))
    else $error("free page count exceeds the bitmap size");

endmodule

/* tb/bitmap_page_allocator_unit_test.sv */
// Self-checking testbench for the bitmap page allocator: predictor, driver and monitor.
`timescale 1ns / 100ps

module bitmap_page_allocator_unit_test;
  import bpa_pkg::*;

  typedef struct packed {
    logic                 operation;
    logic [IN_ADDR_W-1:0] free_address;
  } page_request_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] page_address;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    pages_free;
  } page_reply_t;

  typedef enum {
    K_ALLOC, K_FREE_USED, K_FREE_AGAIN, K_UNALIGNED, K_OUTSIDE, K_NOISE
  } stim_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  bpa_in_if  in_ch();
  bpa_out_if out_ch();

  bitmap_page_allocator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted allocator state
  logic [WORD_W-1:0]  page_map [MAP_WORDS];
  int unsigned        scan_word;
  logic [COUNT_W-1:0] free_count;
  logic [COUNT_W-1:0] tracked_limit;

  page_request_t pending_q [$];
  page_reply_t   reply_q [$];
  bit            touched [longint unsigned];

  int unsigned issued_count;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned config_writes;
  int unsigned pages_allocated, oom_replies, pages_released, frees_rejected;

  function automatic page_reply_t allocate_page();
    page_reply_t     r;
    int unsigned     w;
    int unsigned     b;
    bit              found;
    longint unsigned pg;
    r.page_address = '0;
    r.status       = ST_OOM;
    found          = 1'b0;
    for (int unsigned n = 0; n < MAP_WORDS && !found; n++) begin
      w = (scan_word + n) % MAP_WORDS;
      if (page_map[w] != ALL_USED) begin
        b = 0;
        while (page_map[w][b]) b++;
        page_map[w][b] = 1'b1;
        free_count     = free_count - 1'b1;
        scan_word      = w;
        pg             = longint'(w) * WORD_W + b;
        r.page_address = OUT_ADDR_W'(pg << PAGE_SHIFT);
        r.status       = ST_OK;
        found          = 1'b1;
      end
    end
    r.pages_free = free_count;
    if (found) pages_allocated++;
    else oom_replies++;
    return r;
  endfunction

  function automatic page_reply_t release_page(input logic [IN_ADDR_W-1:0] addr);
    page_reply_t     r;
    longint unsigned pg;
    longint unsigned lim;
    int unsigned     w;
    int unsigned     b;
    pg  = longint'(addr >> PAGE_SHIFT);
    lim = (tracked_limit > PAGE_LIMIT) ? PAGE_LIMIT : tracked_limit;
    r.page_address = '0;
    // alignment wins over range, range over the used check
    if (addr[PAGE_SHIFT-1:0] != '0) begin
      r.status = ST_UNALIGNED;
    end else if (pg >= lim) begin
      r.status = ST_OUTSIDE;
    end else begin
      w = 32'(pg / WORD_W);
      b = 32'(pg % WORD_W);
      if (!page_map[w][b]) begin
        r.status = ST_DOUBLE;
      end else begin
        page_map[w][b] = 1'b0;
        free_count     = free_count + 1'b1;
        if (w < scan_word) scan_word = w;
        r.status = ST_OK;
      end
    end
    r.pages_free = free_count;
    if (r.status == ST_OK) pages_released++;
    else frees_rejected++;
    return r;
  endfunction

  function automatic logic [IN_ADDR_W-1:0] page_addr(input longint unsigned pg);
    return IN_ADDR_W'(pg << PAGE_SHIFT);
  endfunction

  task automatic queue_request(input logic op, input logic [IN_ADDR_W-1:0] addr);
    page_request_t req;
    req.operation    = op;
    req.free_address = addr;
    pending_q.push_back(req);
    issued_count++;
  endtask

  task automatic wait_idle();
    wait (results_checked == issued_count);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tracked_pages(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    tracked_limit  = value;
    config_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: bursts of words with random gaps in between
  page_request_t next_req;
  int unsigned   burst_left;
  int unsigned   gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 1;
      gap_left    <= 0;
    end else if (in_ch.valid && in_ch.ready !== 1'b1) begin
      // hold the word until taken
    end else if (gap_left != 0) begin
      in_ch.valid <= 1'b0;
      gap_left    <= gap_left - 1;
    end else if (pending_q.size() != 0) begin
      next_req           = pending_q.pop_front();
      in_ch.valid        <= 1'b1;
      in_ch.operation    <= next_req.operation;
      in_ch.free_address <= next_req.free_address;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold-off
  int unsigned stall_mode, mode_left, hold_left, words_taken;
  bit          long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      stall_mode     <= 0;
      mode_left      <= 0;
      hold_left      <= 0;
      words_taken    <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) words_taken <= words_taken + 1;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!long_hold_done && words_taken >= 150 && in_ch.valid) begin
        // back up the block while the sender keeps offering
        out_ch.ready   <= 1'b0;
        hold_left      <= 400;
        long_hold_done <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(16, 128);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: predict on request acceptance, compare on result acceptance
  page_reply_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready === 1'b1) begin
        if (in_ch.operation == OP_ALLOC) reply_q.push_back(allocate_page());
        else reply_q.push_back(release_page(in_ch.free_address));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          $error("result with nothing outstanding: page_address %0h status %0d",
                 out_ch.page_address, out_ch.status);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          check_field("page_address", want.page_address, out_ch.page_address);
          check_field("status", want.status, out_ch.status);
          check_field("pages_free", want.pages_free, out_ch.pages_free);
        end
        results_checked++;
      end
    end
  end

  initial begin
    #150_000_000;
    $display("Run timed out with %0d of %0d results seen", results_checked, issued_count);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned         batch, lim, slack, oom_left, oom_budget, pick, tries;
    longint unsigned     pg;
    longint              last_freed;
    bit                  found, oom_batch;
    stim_kind_t          kind;
    logic [IN_ADDR_W-1:0] addr;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_ALLOC;
    in_ch.free_address = '0;
    out_ch.ready       = 1'b0;
    for (int i = 0; i < MAP_WORDS; i++) page_map[i] = ALL_USED;
    scan_word     = 0;
    free_count    = '0;
    tracked_limit = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing tracked, everything used
    set_tracked_pages('0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_FREE, page_addr(0));
    queue_request(OP_FREE, {IN_ADDR_W{1'b1}});
    queue_request(OP_FREE, {{(IN_ADDR_W-PAGE_SHIFT){1'b1}}, {PAGE_SHIFT{1'b0}}});
    wait_idle();

    // Full range: page zero, the top page, double free, wrap to out of memory
    set_tracked_pages(COUNT_W'(PAGE_LIMIT));
    queue_request(OP_FREE, page_addr(0));
    queue_request(OP_ALLOC, {IN_ADDR_W{1'b1}});
    queue_request(OP_FREE, page_addr(0));
    queue_request(OP_FREE, page_addr(0));
    queue_request(OP_FREE, page_addr(PAGE_LIMIT - 1));
    queue_request(OP_FREE, page_addr(PAGE_LIMIT));
    queue_request(OP_FREE, 48'h1);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_ALLOC, '0);
    queue_request(OP_FREE, page_addr(200));
    wait_idle();

    // Shrink the range below a page that is still free
    set_tracked_pages(COUNT_W'(64));
    queue_request(OP_FREE, page_addr(200));
    queue_request(OP_ALLOC, '0);
    queue_request(OP_FREE, page_addr(63));
    queue_request(OP_FREE, page_addr(64));
    queue_request(OP_ALLOC, '0);
    wait_idle();

    oom_budget = 6;
    while (issued_count < 1420) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: set_tracked_pages('0);
          1: set_tracked_pages(COUNT_W'(PAGE_LIMIT));
          2: set_tracked_pages(COUNT_W'(1));
          3: set_tracked_pages(COUNT_W'(65));
          4, 5: set_tracked_pages(COUNT_W'($urandom_range(2, 4096)));
          6: set_tracked_pages(COUNT_W'($urandom_range(1, PAGE_LIMIT)));
          default: set_tracked_pages(COUNT_W'($urandom_range(100, 1500)));
        endcase
      end
      batch     = $urandom_range(20, 60);
      oom_batch = (oom_budget != 0) && ($urandom_range(0, 9) == 0);
      if (oom_batch) oom_budget--;
      lim        = (tracked_limit > PAGE_LIMIT) ? 32'(PAGE_LIMIT) : 32'(tracked_limit);
      // free pages known to remain free through this batch
      slack      = free_count;
      oom_left   = oom_batch ? 2 : 0;
      last_freed = -1;
      touched.delete();
      repeat (batch) begin
        pick = $urandom_range(0, 99);
        if (pick < (oom_batch ? 80 : 45)) kind = K_ALLOC;
        else if (pick < 82) kind = K_FREE_USED;
        else if (pick < 90) kind = K_FREE_AGAIN;
        else if (pick < 95) kind = K_UNALIGNED;
        else if (pick < 98) kind = K_OUTSIDE;
        else kind = K_NOISE;

        if (kind == K_ALLOC) begin
          if (slack != 0) slack--;
          else if (oom_left != 0) oom_left--;
          else kind = K_FREE_USED;
        end
        if (kind == K_FREE_USED && lim == 0) kind = K_OUTSIDE;
        if (kind == K_FREE_USED) begin
          found = 1'b0;
          for (tries = 0; tries < 16 && !found; tries++) begin
            pg    = $urandom_range(0, lim - 1);
            found = page_map[pg / WORD_W][pg % WORD_W] && !touched.exists(pg);
          end
          if (found) slack++;
          else kind = K_FREE_AGAIN;
        end
        if (kind == K_FREE_AGAIN) begin
          if (last_freed >= 0 && $urandom_range(0, 1) == 1) pg = last_freed;
          else pg = (lim != 0) ? $urandom_range(0, lim - 1) : 0;
        end

        case (kind)
          K_ALLOC: addr = {16'($urandom), 32'($urandom)};
          K_FREE_USED, K_FREE_AGAIN: begin
            addr        = page_addr(pg);
            touched[pg] = 1'b1;
            last_freed  = pg;
          end
          K_UNALIGNED: begin
            if ($urandom_range(0, 1) == 1) pg = $urandom_range(0, lim);
            else pg = {4'($urandom), 32'($urandom)};
            addr = page_addr(pg) | IN_ADDR_W'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
          end
          K_OUTSIDE: begin
            if ($urandom_range(0, 1) == 1) pg = lim + $urandom_range(0, 15);
            else pg = {4'($urandom), 32'($urandom)};
            if (pg < lim) pg = lim;
            addr = page_addr(pg);
          end
          default: addr = {16'($urandom), 32'($urandom)};
        endcase
        queue_request((kind == K_ALLOC) ? OP_ALLOC : OP_FREE, addr);
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    $display("Ran %0d requests under %0d range settings", issued_count, config_writes);
    $display("Allocated %0d, out of memory %0d, freed %0d, frees rejected %0d",
             pages_allocated, oom_replies, pages_released, frees_rejected);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (reply_q.size() != 0) $error("%0d results never arrived", reply_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
